// ===== src/cts_pkg.sv =====
// shared types and constants of the chs track segmenter
// no dependencies; imported by every module of the block
`default_nettype none

package cts_pkg;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StGeometry = 2'd1,
    StAlign    = 2'd2,
    StEnd      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgSectorShift    = 2'd0,
    CfgSectorsPerTrk  = 2'd1,
    CfgHeadCount      = 2'd2,
    CfgCylinderCount  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned LbaW      = 14;  // lba range of any valid cylinder
  localparam int unsigned QuoW      = 7;   // cylinder bits
  localparam int unsigned SpcW      = 7;   // heads * sectors per track
  localparam int unsigned SegW      = 16;

  typedef struct packed {
    logic [30:0] byte_offset;
    logic [30:0] remaining_bytes;
    logic        command;
  } cts_in_t;

  typedef struct packed {
    status_e      status;
    logic [6:0]   cylinder;
    logic         head;
    logic [5:0]   sector;
    logic [15:0]  segment_bytes;
    logic         direction;
  } cts_out_t;

  typedef struct packed {
    logic [3:0] sector_shift;
    logic [5:0] trk_sectors;
    logic [1:0] head_count;
    logic [6:0] cylinder_count;
  } cts_cfg_t;

  // payload that moves through the division stages
  typedef struct packed {
    status_e          status;
    logic             direction;
    logic [SegW-1:0]  remain;   // remaining bytes saturated to 16 bits
    logic [LbaW-1:0]  rem;      // partial remainder
    logic [QuoW-1:0]  quo;      // partial quotient (cylinder)
  } cts_div_t;

endpackage

`default_nettype wire

// ===== src/cts_cfg_regs.sv =====
// geometry configuration registers of the chs track segmenter
// depends on cts_pkg
`default_nettype none

module cts_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire cts_pkg::cfg_idx_e              cfg_index_i,
  input  wire logic [cts_pkg::CfgDataW-1:0]   cfg_data_i,
  output cts_pkg::cts_cfg_t                   cfg_o
);
  import cts_pkg::*;

  cts_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sector_shift      <= 4'd9;
      cfg_q.trk_sectors       <= 6'd18;
      cfg_q.head_count        <= 2'd2;
      cfg_q.cylinder_count    <= 7'd80;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSectorShift:   cfg_q.sector_shift      <= cfg_data_i[3:0];
        CfgSectorsPerTrk: cfg_q.trk_sectors       <= cfg_data_i[5:0];
        CfgHeadCount:     cfg_q.head_count        <= cfg_data_i[1:0];
        CfgCylinderCount: cfg_q.cylinder_count    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cts_front.sv =====
// first stage: geometry and alignment checks, sector number and range check
// depends on cts_pkg
`default_nettype none

module cts_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire cts_pkg::cts_in_t   item_i,
  input  wire cts_pkg::cts_cfg_t  cfg_i,
  output logic                    valid_o,
  output cts_pkg::cts_div_t       data_o
);
  import cts_pkg::*;

  logic              geom_bad;
  logic [9:0]        align_mask;
  logic              misaligned;
  logic [30:0]       lba;
  logic [SpcW-1:0]   spc;
  logic [13:0]       limit;
  logic              in_range;
  cts_div_t          data_d;
  cts_div_t          data_q;
  logic              valid_q;

  always_comb begin
    geom_bad = (cfg_i.trk_sectors == 6'd0) || (cfg_i.head_count == 2'd0) ||
               (cfg_i.head_count == 2'd3) || (cfg_i.sector_shift < 4'd7) ||
               (cfg_i.sector_shift > 4'd10);
    align_mask = ~(10'h3FF << cfg_i.sector_shift);
    misaligned = |((item_i.byte_offset[9:0] | item_i.remaining_bytes[9:0]) & align_mask);
    lba        = item_i.byte_offset >> cfg_i.sector_shift;
    // head count is one or two whenever geometry is usable
    spc        = cfg_i.head_count[1] ? {cfg_i.trk_sectors, 1'b0}
                                     : {1'b0, cfg_i.trk_sectors};
    limit      = {7'd0, cfg_i.cylinder_count} * {7'd0, spc};
    in_range   = lba < {17'd0, limit};

    data_d.direction = item_i.command;
    data_d.remain    = (|item_i.remaining_bytes[30:16]) ? {SegW{1'b1}}
                                                        : item_i.remaining_bytes[15:0];
    data_d.quo       = '0;
    data_d.rem       = '0;
    if (geom_bad) begin
      data_d.status = StGeometry;
    end else if (misaligned) begin
      data_d.status = StAlign;
    end else if (item_i.remaining_bytes == 31'd0) begin
      data_d.status = StEnd;
    end else if (!in_range) begin
      data_d.status = StEnd;
    end else begin
      data_d.status = StOk;
      data_d.rem    = lba[LbaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/cts_div.sv =====
// pipelined restoring divider of the sector number by sectors per cylinder
// one quotient bit per register stage; depends on cts_pkg
`default_nettype none

module cts_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire cts_pkg::cts_div_t  data_i,
  input  wire cts_pkg::cts_cfg_t  cfg_i,
  output logic                    valid_o,
  output cts_pkg::cts_div_t       data_o
);
  import cts_pkg::*;

  logic [SpcW-1:0] spc;
  logic            valid_q [QuoW+1];
  cts_div_t        data_q  [QuoW+1];

  assign spc = cfg_i.head_count[1] ? {cfg_i.trk_sectors, 1'b0}
                                   : {1'b0, cfg_i.trk_sectors};

  assign valid_q[0] = valid_i;
  assign data_q[0]  = data_i;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - k;
    logic [LbaW-1:0] divisor;
    logic            take;
    cts_div_t        next_d;
    logic            valid_sq;
    cts_div_t        next_q;

    always_comb begin
      divisor = LbaW'(spc) << Bit;
      take    = data_q[k].rem >= divisor;
      next_d  = data_q[k];
      if (take) begin
        next_d.rem      = data_q[k].rem - divisor;
        next_d.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_sq <= 1'b0;
      end else begin
        valid_sq <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      next_q <= next_d;
    end

    assign valid_q[k+1] = valid_sq;
    assign data_q[k+1]  = next_q;
  end

  assign valid_o = valid_q[QuoW];
  assign data_o  = data_q[QuoW];

endmodule

`default_nettype wire

// ===== src/cts_back.sv =====
// last stage: head and sector from the remainder, track bytes, output register
// depends on cts_pkg
`default_nettype none

module cts_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire cts_pkg::cts_div_t  data_i,
  input  wire cts_pkg::cts_cfg_t  cfg_i,
  output logic                    valid_o,
  output cts_pkg::cts_out_t       result_o
);
  import cts_pkg::*;

  logic [6:0]       trk_sec;
  logic             head;
  logic [6:0]       s0;
  logic [5:0]       left;
  logic [SegW-1:0]  track;
  cts_out_t         result_d;
  cts_out_t         result_q;
  logic             valid_q;

  always_comb begin
    trk_sec = data_i.rem[6:0];
    head    = trk_sec >= {1'b0, cfg_i.trk_sectors};
    s0      = head ? trk_sec - {1'b0, cfg_i.trk_sectors} : trk_sec;
    left    = cfg_i.trk_sectors - s0[5:0];
    track   = {10'd0, left} << cfg_i.sector_shift;

    result_d.status        = data_i.status;
    result_d.direction     = data_i.direction;
    result_d.cylinder      = '0;
    result_d.head          = 1'b0;
    result_d.sector        = '0;
    result_d.segment_bytes = '0;
    if (data_i.status == StOk) begin
      result_d.cylinder      = data_i.quo;
      result_d.head          = head;
      result_d.sector        = s0[5:0] + 6'd1;
      result_d.segment_bytes = (track > data_i.remain) ? data_i.remain : track;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== src/chs_track_segmenter_unit.sv =====
// top level of the chs track segmenter: config registers and the item pipeline
// depends on cts_pkg, cts_cfg_regs, cts_front, cts_div, cts_back
`default_nettype none

// usage
//   command channel: a transaction is taken at a clock edge where start is
//   high and busy is low; busy stays low, so a new transaction may enter in
//   every cycle
//   result channel: done_o is high for one cycle with the result on result_o,
//   after the command has passed the front stage, seven divider stages and
//   the output register; results leave in command order
//   throughput is one transaction per cycle, set by the seven-stage pipelined
//   divider that yields one cylinder bit per stage
//   config channel: cfg_valid_i / cfg_ready_o write the geometry register
//   selected by cfg_index_i; ready is always high; write only while no
//   transaction is in flight
//   the receiver cannot stall, so nothing is ever held back inside the block
//   reset clears all valid bits and loads the default 1.44M floppy geometry
//   (512-byte sectors, 18 sectors per track, 2 heads, 80 cylinders)
module chs_track_segmenter_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire cts_pkg::cts_in_t               cmd_i,
  // result channel
  output logic                                done_o,
  output cts_pkg::cts_out_t                   result_o,
  // configuration channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire cts_pkg::cfg_idx_e              cfg_index_i,
  input  wire logic [cts_pkg::CfgDataW-1:0]   cfg_data_i
);
  import cts_pkg::*;

  cts_cfg_t  cfg;
  logic      front_valid;
  cts_div_t  front_data;
  logic      div_valid;
  cts_div_t  div_data;

  // fully pipelined, never refuses a transaction
  assign busy = 1'b0;

  cts_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // checks, sector number, cylinder range compare
  cts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (cmd_i),
    .cfg_i   (cfg),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  // sector number / sectors per cylinder, remainder is the sector in cylinder
  cts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_data),
    .cfg_i   (cfg),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  // head, sector, clipped track bytes, output register
  cts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .data_i   (div_data),
    .cfg_i    (cfg),
    .valid_o  (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
